// ----- sv/mpcm_pkg.sv -----
// Shared types, constants and the volume gain table for the PCM sample mixer.
`default_nettype none

package mpcm_pkg;

  typedef enum logic [1:0] {
    OP_START    = 2'd0,
    OP_HALT     = 2'd1,
    OP_TICK     = 2'd2,
    OP_HALT_ALL = 2'd3
  } opcode_e;

  localparam int unsigned BYTE_LANES = 4;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned OUT_POS_W  = 16;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned VOL_W      = 4;
  localparam int unsigned GAIN_W     = 8;
  // Four lanes of -128..127 give -512..508.
  localparam int unsigned SUM_W      = 10;
  localparam logic [VOL_W-1:0] VOL_MAX = 4'd8;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = 1;

  typedef struct packed {
    logic [SUM_W-1:0]                     sum;
    logic [BYTE_LANES-1:0]                finished;
    logic [BYTE_LANES-1:0]                active;
    logic [BYTE_LANES-1:0][OUT_POS_W-1:0] next_pos;
  } tick_t;

  function automatic logic [GAIN_W-1:0] vol_gain(input logic [VOL_W-1:0] level);
    logic [GAIN_W-1:0] g;
    unique case (level)
      4'd0:    g = 8'd0;
      4'd1:    g = 8'd12;
      4'd2:    g = 8'd19;
      4'd3:    g = 8'd29;
      4'd4:    g = 8'd45;
      4'd5:    g = 8'd70;
      4'd6:    g = 8'd107;
      4'd7:    g = 8'd165;
      4'd8:    g = 8'd255;
      default: g = 8'd0;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// ----- sv/mpcm_front.sv -----
// Front end: accepts command beats, keeps per-channel play state, forms the raw tick mix.
`default_nettype none

module mpcm_front #(
  parameter int unsigned CHANNEL_COUNT = 4,
  parameter int unsigned POSITION_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire logic [1:0]          opcode_i,
  input  wire logic [1:0]          channel_i,
  input  wire logic [15:0]         sample_length_i,
  input  wire logic [7:0]          byte_ch0_i,
  input  wire logic [7:0]          byte_ch1_i,
  input  wire logic [7:0]          byte_ch2_i,
  input  wire logic [7:0]          byte_ch3_i,
  input  wire logic                q_full_i,
  output      logic                push_o,
  output      mpcm_pkg::tick_t     tick_o
);

  localparam int unsigned LANES = mpcm_pkg::BYTE_LANES;

  logic                     accept;
  logic                     is_start;
  logic                     is_halt;
  logic                     is_tick;
  logic                     is_halt_all;

  logic [CHANNEL_COUNT-1:0] active_q;
  logic [CHANNEL_COUNT-1:0] active_d;
  logic [POSITION_BITS-1:0] pos_q [CHANNEL_COUNT];
  logic [POSITION_BITS-1:0] pos_d [CHANNEL_COUNT];
  logic [POSITION_BITS-1:0] len_q [CHANNEL_COUNT];

  logic [LANES-1:0]                    act_lo;
  logic [LANES-1:0]                    fin_lo;
  logic [LANES-1:0]                    act_next_lo;
  logic [LANES-1:0][mpcm_pkg::OUT_POS_W-1:0] pos_lo;
  logic [LANES-1:0][mpcm_pkg::BYTE_W-1:0]    bytes;
  logic [CHANNEL_COUNT-1:0]            finish;
  logic signed [mpcm_pkg::SUM_W-1:0]   sum;

  assign in_stall_o  = q_full_i;
  assign accept      = in_valid_i && !q_full_i;
  assign is_start    = accept && (opcode_i == mpcm_pkg::OP_START);
  assign is_halt     = accept && (opcode_i == mpcm_pkg::OP_HALT);
  assign is_tick     = accept && (opcode_i == mpcm_pkg::OP_TICK);
  assign is_halt_all = accept && (opcode_i == mpcm_pkg::OP_HALT_ALL);

  assign bytes[0] = byte_ch0_i;
  assign bytes[1] = byte_ch1_i;
  assign bytes[2] = byte_ch2_i;
  assign bytes[3] = byte_ch3_i;

  for (genvar c = 0; c < CHANNEL_COUNT; c++) begin : g_chan
    localparam logic [3:0] IDX = 4'(c);
    logic                     sel;
    logic [POSITION_BITS-1:0] pos_inc;

    // Channel numbers past the top never match, so such starts and halts drop out.
    assign sel       = ({2'b00, channel_i} == IDX);
    assign pos_inc   = pos_q[c] + POSITION_BITS'(1);
    assign finish[c] = is_tick && active_q[c] && (pos_inc >= len_q[c]);

    always_comb begin
      active_d[c] = active_q[c];
      pos_d[c]    = pos_q[c];
      if (is_start && sel) begin
        active_d[c] = 1'b1;
        pos_d[c]    = '0;
      end else if ((is_halt && sel) || is_halt_all) begin
        active_d[c] = 1'b0;
      end else if (is_tick && active_q[c]) begin
        pos_d[c]    = pos_inc;
        active_d[c] = !finish[c];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        active_q[c] <= 1'b0;
        pos_q[c]    <= '0;
      end else begin
        active_q[c] <= active_d[c];
        pos_q[c]    <= pos_d[c];
      end
    end

    always_ff @(posedge clk_i) begin
      if (is_start && sel) begin
        len_q[c] <= POSITION_BITS'(sample_length_i);
      end
    end
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    if (k < CHANNEL_COUNT) begin : g_live
      assign act_lo[k]      = active_q[k];
      assign fin_lo[k]      = finish[k];
      assign act_next_lo[k] = active_d[k];
      assign pos_lo[k]      = mpcm_pkg::OUT_POS_W'(pos_d[k]);
    end else begin : g_none
      assign act_lo[k]      = 1'b0;
      assign fin_lo[k]      = 1'b0;
      assign act_next_lo[k] = 1'b0;
      assign pos_lo[k]      = '0;
    end
  end

  // Flip bit 7 to turn offset-binary bytes into two's complement, then add the lanes of playing channels.
  always_comb begin
    sum = '0;
    for (int k = 0; k < LANES; k++) begin
      if (act_lo[k]) begin
        sum = sum + mpcm_pkg::SUM_W'($signed({~bytes[k][7], bytes[k][6:0]}));
      end
    end
  end

  assign push_o          = is_tick;
  assign tick_o.sum      = sum;
  assign tick_o.finished = fin_lo;
  assign tick_o.active   = act_next_lo;
  assign tick_o.next_pos = pos_lo;

endmodule

`default_nettype wire

// ----- sv/mpcm_queue.sv -----
// Two-entry queue of tick beats between the front end and the scaling back end.
`default_nettype none

module mpcm_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire mpcm_pkg::tick_t data_i,
  input  wire logic            pop_i,
  output      logic            full_o,
  output      logic            valid_o,
  output      mpcm_pkg::tick_t data_o
);

  localparam int unsigned AW = mpcm_pkg::Q_AW;
  localparam logic [AW:0] DEPTH = (AW + 1)'(mpcm_pkg::Q_DEPTH);

  mpcm_pkg::tick_t mem_q [mpcm_pkg::Q_DEPTH];
  logic [AW-1:0]   wr_ptr_q;
  logic [AW-1:0]   rd_ptr_q;
  logic [AW:0]     count_q;
  logic [AW:0]     count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (count_q == DEPTH);
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + (AW + 1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (AW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ----- sv/mpcm_back.sv -----
// Back end: applies volume gain, halves toward zero, clips to 16 bits, holds the result beat.
`default_nettype none

module mpcm_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  q_valid_i,
  input  wire mpcm_pkg::tick_t       q_data_i,
  output      logic                  q_pop_o,
  input  wire logic [3:0]            volume_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  output      logic signed [15:0]    mixed_sample_o,
  output      logic [3:0]            finished_mask_o,
  output      logic [3:0]            active_mask_o,
  output      logic [15:0]           next_pos_ch0_o,
  output      logic [15:0]           next_pos_ch1_o,
  output      logic [15:0]           next_pos_ch2_o,
  output      logic [15:0]           next_pos_ch3_o
);

  localparam int unsigned PW = mpcm_pkg::SUM_W + mpcm_pkg::GAIN_W + 1;
  localparam int unsigned SW = mpcm_pkg::SAMPLE_W;

  logic                 valid_q;
  logic signed [mpcm_pkg::GAIN_W:0] gain;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_adj;
  logic signed [PW-1:0] half;
  logic [SW-1:0]        clipped;
  logic                 all_zero;
  logic                 all_one;

  assign q_pop_o = q_valid_i && (!valid_q || !out_stall_i);

  assign gain     = $signed({1'b0, mpcm_pkg::vol_gain(volume_i)});
  assign prod     = $signed(q_data_i.sum) * gain;
  // Add one before the shift on negatives so the halving truncates toward zero.
  assign prod_adj = prod + $signed({{(PW-1){1'b0}}, prod[PW-1]});
  assign half     = prod_adj >>> 1;

  assign all_zero = ~|half[PW-2:SW-1];
  assign all_one  = &half[PW-2:SW-1];

  always_comb begin
    clipped = half[SW-1:0];
    if (!half[PW-1] && !all_zero) begin
      clipped = {1'b0, {(SW-1){1'b1}}};
    end else if (half[PW-1] && !all_one) begin
      clipped = {1'b1, {(SW-1){1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (q_pop_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      mixed_sample_o  <= $signed(clipped);
      finished_mask_o <= q_data_i.finished;
      active_mask_o   <= q_data_i.active;
      next_pos_ch0_o  <= q_data_i.next_pos[0];
      next_pos_ch1_o  <= q_data_i.next_pos[1];
      next_pos_ch2_o  <= q_data_i.next_pos[2];
      next_pos_ch3_o  <= q_data_i.next_pos[3];
    end
  end

  assign out_valid_o = valid_q;

endmodule

`default_nettype wire

// ----- sv/multichannel_pcm_sample_mixer.sv -----
// Four-channel PCM sample mixer with volume scaling and 16-bit clipping.
//
// Input channel (in_valid_i / in_stall_o): one command beat per accepted cycle.
//   Start arms a channel with a length and rewinds it, halt and halt-all disarm,
//   and a tick mixes the byte offered for each playing channel.
// Output channel (out_valid_o / out_stall_i): one result beat per tick; the
//   other commands produce nothing.
// Configuration: cfg_we_i writes cfg_wdata_i into the volume level; values
//   above 8 are dropped. Write it only while no tick is in flight.
// Throughput: one beat per cycle while in_stall_o is low. Channel state is updated in the cycle the
//   beat is taken, so back-to-back commands see each other's effect.
// Path: a tick is written into the queue when it is taken, then passes through the
//   gain multiplier into the output register, from which its result can be taken.
// Stalls: a stalled result holds; the two-entry queue absorbs ticks until it
//   fills, then in_stall_o rises.
// Reset: all channels idle at position zero, volume zero, both sides empty.
`default_nettype none

module multichannel_pcm_sample_mixer #(
  parameter int unsigned CHANNEL_COUNT = 4,
  parameter int unsigned POSITION_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [3:0]         cfg_wdata_i,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic [1:0]         opcode_i,
  input  wire logic [1:0]         channel_i,
  input  wire logic [15:0]        sample_length_i,
  input  wire logic [7:0]         byte_ch0_i,
  input  wire logic [7:0]         byte_ch1_i,
  input  wire logic [7:0]         byte_ch2_i,
  input  wire logic [7:0]         byte_ch3_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic signed [15:0] mixed_sample_o,
  output      logic [3:0]         finished_mask_o,
  output      logic [3:0]         active_mask_o,
  output      logic [15:0]        next_pos_ch0_o,
  output      logic [15:0]        next_pos_ch1_o,
  output      logic [15:0]        next_pos_ch2_o,
  output      logic [15:0]        next_pos_ch3_o
);

  logic [mpcm_pkg::VOL_W-1:0] volume_q;
  logic                       push;
  mpcm_pkg::tick_t            tick;
  logic                       q_full;
  logic                       q_valid;
  mpcm_pkg::tick_t            q_data;
  logic                       q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volume_q <= '0;
    end else if (cfg_we_i && (cfg_wdata_i <= mpcm_pkg::VOL_MAX)) begin
      volume_q <= cfg_wdata_i;
    end
  end

  mpcm_front #(
    .CHANNEL_COUNT(CHANNEL_COUNT),
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .channel_i      (channel_i),
    .sample_length_i(sample_length_i),
    .byte_ch0_i     (byte_ch0_i),
    .byte_ch1_i     (byte_ch1_i),
    .byte_ch2_i     (byte_ch2_i),
    .byte_ch3_i     (byte_ch3_i),
    .q_full_i       (q_full),
    .push_o         (push),
    .tick_o         (tick)
  );

  mpcm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (tick),
    .pop_i  (q_pop),
    .full_o (q_full),
    .valid_o(q_valid),
    .data_o (q_data)
  );

  mpcm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_data_i       (q_data),
    .q_pop_o        (q_pop),
    .volume_i       (volume_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .mixed_sample_o (mixed_sample_o),
    .finished_mask_o(finished_mask_o),
    .active_mask_o  (active_mask_o),
    .next_pos_ch0_o (next_pos_ch0_o),
    .next_pos_ch1_o (next_pos_ch1_o),
    .next_pos_ch2_o (next_pos_ch2_o),
    .next_pos_ch3_o (next_pos_ch3_o)
  );

  // A channel that finished on a tick cannot also be reported as playing.
  a_fin_not_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((finished_mask_o & active_mask_o) == 4'd0))
    else $error("finished and active masks overlap");

  // The volume register never holds a level past the table.
  a_vol_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    volume_q <= mpcm_pkg::VOL_MAX)
    else $error("volume level out of range");

  // A tick entering an empty pipeline passes through the queue and reaches the output.
  a_tick_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !q_valid && !out_valid_o) |-> ##2 out_valid_o)
    else $error("tick result missing");

  // Non-tick commands never create a result.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!push && !q_valid && !out_valid_o) |=> !out_valid_o)
    else $error("result without a tick");

endmodule

`default_nettype wire

// ----- dv/multichannel_pcm_sample_mixer_tb.sv -----
// Self-checking testbench for the four-channel PCM sample mixer.
`default_nettype none

module multichannel_pcm_sample_mixer_tb;

  localparam int CH_N        = 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 4;
  localparam int LONG_HOLD   = 60;

  typedef struct packed {
    mpcm_pkg::opcode_e op;
    logic [1:0]        ch;
    logic [15:0]       len;
    logic [3:0][7:0]   bytes;
  } mixer_cmd_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [3:0]         finished;
    logic [3:0]         active;
    logic [3:0][15:0]   pos;
  } mix_result_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              cfg_we     = 1'b0;
  logic [3:0]        cfg_wdata  = 4'd0;
  logic              in_valid   = 1'b0;
  mpcm_pkg::opcode_e opcode     = mpcm_pkg::OP_TICK;
  logic [1:0]        channel    = 2'd0;
  logic [15:0]       sample_len = 16'd0;
  logic [7:0]        byte0      = 8'h80;
  logic [7:0]        byte1      = 8'h80;
  logic [7:0]        byte2      = 8'h80;
  logic [7:0]        byte3      = 8'h80;
  logic              out_stall  = 1'b0;

  wire logic               in_stall;
  wire logic               out_valid;
  wire logic signed [15:0] mixed_sample;
  wire logic [3:0]         finished_mask;
  wire logic [3:0]         active_mask;
  wire logic [15:0]        next_pos0;
  wire logic [15:0]        next_pos1;
  wire logic [15:0]        next_pos2;
  wire logic [15:0]        next_pos3;

  // Mixer state as the testbench sees it.
  logic [3:0]  ch_playing = 4'd0;
  logic [15:0] ch_pos [CH_N];
  logic [15:0] ch_len [CH_N];
  logic [3:0]  vol_level = 4'd0;
  int          gain_lut [0:8] = '{0, 12, 19, 29, 45, 70, 107, 165, 255};

  mix_result_t pending_mixes [$];
  mix_result_t got_mix;
  mix_result_t want_mix;

  int   error_count = 0;
  int   cycle_count = 0;
  bit   idling_on   = 1'b1;
  bit   hold_req    = 1'b0;
  int   hold_left   = 0;
  int   burst_left  = 0;

  multichannel_pcm_sample_mixer dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .opcode_i        (opcode),
    .channel_i       (channel),
    .sample_length_i (sample_len),
    .byte_ch0_i      (byte0),
    .byte_ch1_i      (byte1),
    .byte_ch2_i      (byte2),
    .byte_ch3_i      (byte3),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .mixed_sample_o  (mixed_sample),
    .finished_mask_o (finished_mask),
    .active_mask_o   (active_mask),
    .next_pos_ch0_o  (next_pos0),
    .next_pos_ch1_o  (next_pos1),
    .next_pos_ch2_o  (next_pos2),
    .next_pos_ch3_o  (next_pos3)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("multichannel_pcm_sample_mixer_tb: done, errors");
      $finish;
    end
  end

  // Apply one accepted command beat to the state and queue the mix a tick makes.
  function automatic void mix_model_step(input mixer_cmd_t c);
    int          sum;
    int          scaled;
    logic [7:0]  flipped;
    mix_result_t r;
    unique case (c.op)
      mpcm_pkg::OP_START: begin
        ch_pos[c.ch]     = 16'd0;
        ch_len[c.ch]     = c.len;
        ch_playing[c.ch] = 1'b1;
      end
      mpcm_pkg::OP_HALT: ch_playing[c.ch] = 1'b0;
      mpcm_pkg::OP_HALT_ALL: ch_playing = 4'd0;
      default: begin
        sum = 0;
        r.finished = 4'd0;
        for (int i = 0; i < CH_N; i++) begin
          if (ch_playing[i]) begin
            flipped = c.bytes[i] ^ 8'h80;
            sum += int'($signed(flipped));
            ch_pos[i] = ch_pos[i] + 16'd1;
            if (ch_pos[i] >= ch_len[i]) begin
              ch_playing[i]  = 1'b0;
              r.finished[i] = 1'b1;
            end
          end
        end
        scaled = (sum * gain_lut[vol_level]) / 2;
        if (scaled > 32767) scaled = 32767;
        else if (scaled < -32768) scaled = -32768;
        r.sample = 16'(scaled);
        r.active = ch_playing;
        for (int i = 0; i < CH_N; i++) r.pos[i] = ch_pos[i];
        pending_mixes.push_back(r);
      end
    endcase
  endfunction

  // Predict on every accepted input beat.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      mix_model_step('{opcode, channel, sample_len, {byte3, byte2, byte1, byte0}});
  end

  // Compare every accepted result beat against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_mix = '{mixed_sample, finished_mask, active_mask,
                  {next_pos3, next_pos2, next_pos1, next_pos0}};
      if (pending_mixes.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result beat: sample %0d fin %h act %h",
                   got_mix.sample, got_mix.finished, got_mix.active);
      end else begin
        want_mix = pending_mixes.pop_front();
        if (got_mix.sample !== want_mix.sample || got_mix.finished !== want_mix.finished ||
            got_mix.active !== want_mix.active || got_mix.pos !== want_mix.pos) begin
          error_count++;
          if (error_count <= 10)
            $display("mix mismatch: exp sample %0d fin %h act %h pos %h | got %0d %h %h %h",
                     want_mix.sample, want_mix.finished, want_mix.active, want_mix.pos,
                     got_mix.sample, got_mix.finished, got_mix.active, got_mix.pos);
        end
      end
    end
  end

  // Receiver: random stall bursts, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!idling_on) begin
      out_stall <= 1'b0;
    end else if (burst_left != 0) begin
      burst_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      burst_left = $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic mixer_cmd_t make_cmd(input mpcm_pkg::opcode_e op, input logic [1:0] ch,
                                          input logic [15:0] len,
                                          input logic [3:0][7:0] bytes);
    mixer_cmd_t c;
    c.op    = op;
    c.ch    = ch;
    c.len   = len;
    c.bytes = bytes;
    return c;
  endfunction

  function automatic mixer_cmd_t random_cmd();
    mixer_cmd_t c;
    int         pick;
    pick = $urandom_range(0, 99);
    c.ch = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 4) == 0) c.len = 16'($urandom_range(0, 65535));
    else c.len = 16'($urandom_range(0, 12));
    for (int i = 0; i < CH_N; i++) c.bytes[i] = 8'($urandom_range(0, 255));
    if (ch_playing == 4'd0 && pick < 70) c.op = mpcm_pkg::OP_START;
    else if (pick < 22) c.op = mpcm_pkg::OP_START;
    else if (pick < 32) c.op = mpcm_pkg::OP_HALT;
    else if (pick < 36) c.op = mpcm_pkg::OP_HALT_ALL;
    else c.op = mpcm_pkg::OP_TICK;
    return c;
  endfunction

  // Offer one beat; return at the edge that accepts it with valid still high.
  task automatic send_cmd(input mixer_cmd_t c);
    int gap;
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 7);
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= c.op;
    channel    <= c.ch;
    sample_len <= c.len;
    byte0      <= c.bytes[0];
    byte1      <= c.bytes[1];
    byte2      <= c.bytes[2];
    byte3      <= c.bytes[3];
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted mix has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_mixes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_volume(input logic [3:0] lvl);
    cfg_we    <= 1'b1;
    cfg_wdata <= lvl;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (lvl <= mpcm_pkg::VOL_MAX) vol_level = lvl;
    @(posedge clk);
  endtask

  task automatic test_idle_tick();
    send_cmd(make_cmd(mpcm_pkg::OP_TICK, 2'd0, 16'd0, {4{8'hFF}}));
    drain_results();
  endtask

  task automatic test_saturation();
    write_volume(4'd8);
    for (int i = 0; i < CH_N; i++)
      send_cmd(make_cmd(mpcm_pkg::OP_START, 2'(i), 16'd5, '0));
    send_cmd(make_cmd(mpcm_pkg::OP_TICK, 2'd0, 16'd0, {4{8'hFF}}));
    send_cmd(make_cmd(mpcm_pkg::OP_TICK, 2'd0, 16'd0, {4{8'h00}}));
    send_cmd(make_cmd(mpcm_pkg::OP_TICK, 2'd0, 16'd0, {8'hFE, 8'h01, 8'h7F, 8'h80}));
    send_cmd(make_cmd(mpcm_pkg::OP_HALT_ALL, 2'd0, 16'd0, '0));
    drain_results();
  endtask

  task automatic test_zero_length_halt();
    write_volume(4'd4);
    send_cmd(make_cmd(mpcm_pkg::OP_START, 2'd0, 16'd0, '0));
    send_cmd(make_cmd(mpcm_pkg::OP_START, 2'd1, 16'hFFFF, '0));
    send_cmd(make_cmd(mpcm_pkg::OP_START, 2'd2, 16'd2, '0));
    send_cmd(make_cmd(mpcm_pkg::OP_START, 2'd3, 16'd1, '0));
    send_cmd(make_cmd(mpcm_pkg::OP_TICK, 2'd0, 16'd0, {8'h10, 8'hE0, 8'h90, 8'h33}));
    // A halted channel keeps its position.
    send_cmd(make_cmd(mpcm_pkg::OP_HALT, 2'd1, 16'd0, '0));
    send_cmd(make_cmd(mpcm_pkg::OP_TICK, 2'd0, 16'd0, {8'h55, 8'hAA, 8'hC3, 8'h3C}));
    send_cmd(make_cmd(mpcm_pkg::OP_TICK, 2'd0, 16'd0, {8'h01, 8'hFE, 8'h7F, 8'h80}));
    send_cmd(make_cmd(mpcm_pkg::OP_START, 2'd1, 16'd3, '0));
    send_cmd(make_cmd(mpcm_pkg::OP_TICK, 2'd0, 16'd0, {8'hFF, 8'h00, 8'hFF, 8'h00}));
    send_cmd(make_cmd(mpcm_pkg::OP_HALT_ALL, 2'd0, 16'd0, '0));
    send_cmd(make_cmd(mpcm_pkg::OP_TICK, 2'd0, 16'd0, {4{8'hFF}}));
    drain_results();
  endtask

  task automatic test_volume_range();
    write_volume(4'd5);
    write_volume(4'd15);
    write_volume(4'd9);
    send_cmd(make_cmd(mpcm_pkg::OP_START, 2'd2, 16'd2, '0));
    send_cmd(make_cmd(mpcm_pkg::OP_TICK, 2'd0, 16'd0, {8'h80, 8'hF0, 8'h80, 8'h80}));
    send_cmd(make_cmd(mpcm_pkg::OP_TICK, 2'd0, 16'd0, {8'h80, 8'h0F, 8'h80, 8'h80}));
    drain_results();
  endtask

  // Hold the output while ticks keep coming so the block fills and stalls.
  task automatic test_backpressure();
    logic [3:0][7:0] b;
    write_volume(4'd6);
    @(negedge clk);
    hold_req = 1'b1;
    @(posedge clk);
    for (int i = 0; i < CH_N; i++)
      send_cmd(make_cmd(mpcm_pkg::OP_START, 2'(i), 16'd20, '0));
    repeat (36) begin
      for (int i = 0; i < CH_N; i++) b[i] = 8'($urandom_range(0, 255));
      send_cmd(make_cmd(mpcm_pkg::OP_TICK, 2'd0, 16'd0, b));
    end
    drain_results();
  endtask

  task automatic test_random_mix();
    logic [3:0] lvl;
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) lvl = 4'd8;
      else if (phase == 1) lvl = 4'd0;
      else lvl = 4'($urandom_range(0, 15));
      write_volume(lvl);
      for (int k = 0; k < 60; k++) begin
        send_cmd(random_cmd());
        // Pause the sender until everything outstanding is out.
        if (phase == 3 && k == 30) drain_results();
      end
      drain_results();
    end
  endtask

  task automatic test_no_idle_tail();
    @(negedge clk);
    idling_on = 1'b0;
    @(posedge clk);
    write_volume(4'd7);
    repeat (40) send_cmd(random_cmd());
    drain_results();
  endtask

  initial begin
    for (int i = 0; i < CH_N; i++) begin
      ch_pos[i] = 16'd0;
      ch_len[i] = 16'd0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_tick();
    test_saturation();
    test_zero_length_halt();
    test_volume_range();
    test_backpressure();
    test_random_mix();
    test_no_idle_tail();
    if (pending_mixes.size() != 0) error_count++;
    if (error_count == 0)
      $display("multichannel_pcm_sample_mixer_tb: done, clean");
    else
      $display("multichannel_pcm_sample_mixer_tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
sv/mpcm_pkg.sv
sv/mpcm_front.sv
sv/mpcm_queue.sv
sv/mpcm_back.sv
sv/multichannel_pcm_sample_mixer.sv
dv/multichannel_pcm_sample_mixer_tb.sv
